[rtl/dashed_line_vertex_expander_core_defines.svh]
// Assertion macros for the dashed line vertex expander core
`ifndef DASHED_LINE_VERTEX_EXPANDER_CORE_DEFINES_SVH
`define DASHED_LINE_VERTEX_EXPANDER_CORE_DEFINES_SVH
`define DLVE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlve assertion failed");
`define DLVE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlve assertion failed");
`endif

[rtl/dlve_pkg.sv]
// Shared types and constants for the dashed line vertex expander
`timescale 1ns / 1ps
package dlve_pkg;
  localparam int BUFFER_DEPTH = 64;
  localparam int LIM = (BUFFER_DEPTH - 1 > 63) ? 63 : BUFFER_DEPTH - 1;
  localparam int KW = 7;
  localparam int QDEPTH = 2;

  localparam logic [1:0] STYLE_DASHED = 2'd1;
  localparam logic [1:0] STYLE_DASHDOT = 2'd2;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] ex;
    logic [31:0] ey;
    logic        se;
    logic        ee;
    logic        dashed;
    logic        plen4;
    logic [32:0] c1;
    logic [32:0] len;
    logic [31:0] stx1;
    logic [31:0] sty1;
    logic [31:0] stx2;
    logic [31:0] sty2;
    logic [KW-1:0] f;
  } seg_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  typedef enum logic [2:0] {
    SU_IDLE, SU_SQ_MUL, SU_SQ_ACC, SU_SQRT, SU_DV_MUL, SU_DV_ACC, SU_DIV, SU_PUSH
  } setup_state_t;

  typedef enum logic [1:0] {
    EM_IDLE, EM_COUNT, EM_EMIT
  } emit_state_t;
endpackage

[rtl/dlve_setup.sv]
// Segment setup: length by square root and per-phase steps by division
`timescale 1ns / 1ps
module dlve_setup (
  input  logic                clk,
  input  logic                rst,
  input  logic                seg_valid,
  output logic                seg_stall,
  input  logic signed [31:0]  start_x,
  input  logic signed [31:0]  start_y,
  input  logic                start_endside,
  input  logic signed [31:0]  end_x,
  input  logic signed [31:0]  end_y,
  input  logic                end_endside,
  input  logic [1:0]          line_style,
  input  logic [30:0]         dash_length,
  input  logic [5:0]          buffer_fill,
  output dlve_pkg::qctl_t     qctl_push,
  input  logic                q_full,
  output dlve_pkg::seg_t      rec
);
  localparam int KW = dlve_pkg::KW;

  dlve_pkg::setup_state_t state, state_next;

  logic [31:0] sx, sy, ex, ey;
  logic        se, ee;
  logic [1:0]  style;
  logic [30:0] dash;
  logic [KW-1:0] f;
  logic [32:0] adx, ady;
  logic        sgnx, sgny;
  logic [65:0] acc;
  logic [49:0] prod;
  logic [1:0]  j;
  logic [1:0]  d;
  logic [5:0]  cnt;
  logic [34:0] srem;
  logic [32:0] root;
  logic [32:0] len;
  logic        dashed;
  logic [32:0] drem;
  logic [33:0] nlo;
  logic [33:0] q;
  logic [31:0] steps [4];

  logic signed [32:0] dxw, dyw;
  logic [32:0] adx_in, ady_in;
  logic [KW-1:0] fill1, f_in;
  logic [32:0] c1, c2, mx, ma;
  logic [16:0] mb;
  logic [65:0] acc_next;
  logic [36:0] srem_sh, strial;
  logic        sge;
  logic [32:0] root_next;
  logic [33:0] drem_sh;
  logic        dge;
  logic [33:0] q_next;
  logic        accept;

  assign dxw = {end_x[31], end_x} - {start_x[31], start_x};
  assign dyw = {end_y[31], end_y} - {start_y[31], start_y};
  assign adx_in = dxw[32] ? 33'(-dxw) : 33'(dxw);
  assign ady_in = dyw[32] ? 33'(-dyw) : 33'(dyw);
  assign fill1 = KW'(buffer_fill) + KW'(1);
  assign f_in = (fill1 > KW'(dlve_pkg::LIM - 1)) ? KW'(dlve_pkg::LIM - 1) : fill1;

  assign c1 = (dash != 31'd0) ? {2'b00, dash} : len;
  assign c2 = c1 >> 2;

  always_comb begin
    if (state == dlve_pkg::SU_SQ_MUL) begin
      ma = j[1] ? ady : adx;
      mx = ma;
    end else begin
      ma = d[0] ? ady : adx;
      mx = d[1] ? c2 : c1;
    end
    mb = j[0] ? {1'b0, mx[32:17]} : mx[16:0];
  end

  assign acc_next = acc + (j[0] ? 66'({prod, 17'b0}) : 66'(prod));

  assign srem_sh = {srem[34:0], acc[65:64]};
  assign strial = {2'b00, root, 2'b01};
  assign sge = srem_sh >= strial;
  assign root_next = {root[31:0], sge};

  assign drem_sh = {drem, nlo[33]};
  assign dge = drem_sh >= {1'b0, len};
  assign q_next = {q[32:0], dge};

  assign accept = (state == dlve_pkg::SU_IDLE) && seg_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      dlve_pkg::SU_IDLE:   if (seg_valid) state_next = dlve_pkg::SU_SQ_MUL;
      dlve_pkg::SU_SQ_MUL: state_next = dlve_pkg::SU_SQ_ACC;
      dlve_pkg::SU_SQ_ACC: state_next = (j == 2'd3) ? dlve_pkg::SU_SQRT : dlve_pkg::SU_SQ_MUL;
      dlve_pkg::SU_SQRT: begin
        if (cnt == 6'd32) begin
          state_next = (((style == dlve_pkg::STYLE_DASHED) ||
                         (style == dlve_pkg::STYLE_DASHDOT)) && (root_next != 33'd0))
                       ? dlve_pkg::SU_DV_MUL : dlve_pkg::SU_PUSH;
        end
      end
      dlve_pkg::SU_DV_MUL: state_next = dlve_pkg::SU_DV_ACC;
      dlve_pkg::SU_DV_ACC: state_next = (j == 2'd1) ? dlve_pkg::SU_DIV : dlve_pkg::SU_DV_MUL;
      dlve_pkg::SU_DIV: begin
        if (cnt == 6'd33) state_next = (d == 2'd3) ? dlve_pkg::SU_PUSH : dlve_pkg::SU_DV_MUL;
      end
      dlve_pkg::SU_PUSH:   if (!q_full) state_next = dlve_pkg::SU_IDLE;
      default:             state_next = dlve_pkg::SU_IDLE;
    endcase
  end

  always_comb begin
    seg_stall = (state != dlve_pkg::SU_IDLE);
    qctl_push.push = (state == dlve_pkg::SU_PUSH) && !q_full;
    qctl_push.full = q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlve_pkg::SU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dlve_pkg::SU_IDLE: begin
        if (accept) begin
          sx <= start_x;
          sy <= start_y;
          ex <= end_x;
          ey <= end_y;
          se <= start_endside;
          ee <= end_endside;
          style <= line_style;
          dash <= dash_length;
          f <= f_in;
          adx <= adx_in;
          ady <= ady_in;
          sgnx <= dxw[32];
          sgny <= dyw[32];
          acc <= 66'd0;
          j <= 2'd0;
        end
      end
      dlve_pkg::SU_SQ_MUL, dlve_pkg::SU_DV_MUL: begin
        prod <= ma * mb;
      end
      dlve_pkg::SU_SQ_ACC: begin
        acc <= acc_next;
        j <= j + 2'd1;
        srem <= 35'd0;
        root <= 33'd0;
        cnt <= 6'd0;
      end
      dlve_pkg::SU_SQRT: begin
        srem <= sge ? 35'(srem_sh - strial) : srem_sh[34:0];
        root <= root_next;
        acc <= {acc[63:0], 2'b00};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          len <= root_next;
          dashed <= ((style == dlve_pkg::STYLE_DASHED) ||
                     (style == dlve_pkg::STYLE_DASHDOT)) && (root_next != 33'd0);
          d <= 2'd0;
          j <= 2'd0;
          acc <= 66'd0;
        end
      end
      dlve_pkg::SU_DV_ACC: begin
        acc <= acc_next;
        j <= j + 2'd1;
        drem <= {1'b0, acc_next[65:34]};
        nlo <= acc_next[33:0];
        q <= 34'd0;
        cnt <= 6'd0;
      end
      dlve_pkg::SU_DIV: begin
        drem <= dge ? 33'(drem_sh - {1'b0, len}) : drem_sh[32:0];
        nlo <= {nlo[32:0], 1'b0};
        q <= q_next;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd33) begin
          steps[d] <= (d[0] ? sgny : sgnx) ? 32'(34'd0 - q_next) : q_next[31:0];
          d <= d + 2'd1;
          j <= 2'd0;
          acc <= 66'd0;
        end
      end
      dlve_pkg::SU_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rec.sx = sx;
    rec.sy = sy;
    rec.ex = ex;
    rec.ey = ey;
    rec.se = se;
    rec.ee = ee;
    rec.dashed = dashed;
    rec.plen4 = (style == dlve_pkg::STYLE_DASHDOT);
    rec.c1 = c1;
    rec.len = len;
    rec.stx1 = steps[0];
    rec.sty1 = steps[1];
    rec.stx2 = steps[2];
    rec.sty2 = steps[3];
    rec.f = f;
  end
endmodule

[rtl/dlve_queue.sv]
// Two-entry queue of segment records between setup and vertex emission
`timescale 1ns / 1ps
module dlve_queue (
  input  logic              clk,
  input  logic              rst,
  input  dlve_pkg::qctl_t   qctl_push,
  input  dlve_pkg::seg_t    wr_rec,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output dlve_pkg::seg_t    rd_rec
);
  dlve_pkg::seg_t mem [dlve_pkg::QDEPTH];
  logic       wp, rp;
  logic [1:0] count;

  assign full = (count == 2'(dlve_pkg::QDEPTH));
  assign rd_valid = (count != 2'd0);
  assign rd_rec = mem[rp];

  always_ff @(posedge clk) begin
    if (qctl_push.push) mem[wp] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (qctl_push.push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(qctl_push.push) - 2'(pop);
    end
  end
endmodule

[rtl/dlve_emit.sv]
// Vertex emission: pattern count pass for dashed segments, then one vertex per cycle while not stalled
`timescale 1ns / 1ps
module dlve_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            rec_valid,
  input  dlve_pkg::seg_t  rec_in,
  output logic            rec_pop,
  output logic            vtx_valid,
  input  logic            vtx_stall,
  output logic [31:0]     out_x,
  output logic [31:0]     out_y,
  output logic            pen_down,
  output logic            endside_mark,
  output logic [5:0]      vertex_index,
  output logic            last_vertex
);
  localparam int KW = dlve_pkg::KW;
  localparam logic [KW-1:0] LIMK = KW'(dlve_pkg::LIM);

  dlve_pkg::emit_state_t state, state_next;
  dlve_pkg::seg_t r;

  logic [KW-1:0] k, kf, e_idx;
  logic [35:0]   dlen;
  logic [1:0]    ph;
  logic [31:0]   px, py;

  logic [32:0]   c;
  logic [35:0]   dl;
  logic          hit, cdone;
  logic [KW-1:0] kf_cnt;
  logic [1:0]    ph_next;
  logic          load;
  logic [31:0]   nx, ny;

  assign c = (ph == 2'd0) ? r.c1 : (r.c1 >> 2);
  assign dl = dlen + 36'(c);
  assign hit = dl >= 36'(r.len);
  assign ph_next = r.plen4 ? ph + 2'd1 : {1'b0, ~ph[0]};
  assign nx = px + ((ph == 2'd0) ? r.stx1 : r.stx2);
  assign ny = py + ((ph == 2'd0) ? r.sty1 : r.sty2);

  always_comb begin
    cdone = 1'b0;
    kf_cnt = k;
    if (!ph[0]) begin
      if (k == LIMK) begin
        cdone = 1'b1;
        kf_cnt = LIMK;
      end else if (hit) begin
        cdone = 1'b1;
        kf_cnt = k + KW'(1);
      end
    end else if (hit || (k == LIMK)) begin
      cdone = 1'b1;
      kf_cnt = k;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dlve_pkg::EM_IDLE: begin
        if (rec_valid) state_next = rec_in.dashed ? dlve_pkg::EM_COUNT : dlve_pkg::EM_EMIT;
      end
      dlve_pkg::EM_COUNT: if (cdone) state_next = dlve_pkg::EM_EMIT;
      dlve_pkg::EM_EMIT:  if (load && (e_idx == kf)) state_next = dlve_pkg::EM_IDLE;
      default:            state_next = dlve_pkg::EM_IDLE;
    endcase
  end

  always_comb begin
    rec_pop = (state == dlve_pkg::EM_IDLE) && rec_valid;
    load = (state == dlve_pkg::EM_EMIT) && (!vtx_valid || !vtx_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlve_pkg::EM_IDLE;
      vtx_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) vtx_valid <= 1'b1;
      else if (!vtx_stall) vtx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dlve_pkg::EM_IDLE: begin
        if (rec_valid) begin
          r <= rec_in;
          k <= rec_in.f;
          kf <= rec_in.f + KW'(1);
          e_idx <= rec_in.f;
          dlen <= 36'd0;
          ph <= 2'd0;
          px <= rec_in.sx;
          py <= rec_in.sy;
        end
      end
      dlve_pkg::EM_COUNT: begin
        dlen <= dl;
        ph <= ph_next;
        k <= k + KW'(1);
        if (cdone) begin
          kf <= kf_cnt;
          k <= kf_cnt;
          ph <= 2'd0;
        end
      end
      dlve_pkg::EM_EMIT: begin
        if (load) begin
          vertex_index <= e_idx[5:0];
          endside_mark <= (e_idx <= KW'((kf + r.f - KW'(1)) >> 1)) ? r.se : r.ee;
          last_vertex <= (e_idx == kf);
          e_idx <= e_idx + KW'(1);
          if (e_idx == r.f) begin
            out_x <= r.sx;
            out_y <= r.sy;
            pen_down <= 1'b0;
          end else if (e_idx == kf) begin
            out_x <= r.ex;
            out_y <= r.ey;
            pen_down <= 1'b1;
          end else begin
            out_x <= nx;
            out_y <= ny;
            pen_down <= !ph[0];
            px <= nx;
            py <= ny;
            ph <= ph_next;
          end
        end
      end
      default: begin
      end
    endcase
  end
endmodule

[rtl/dashed_line_vertex_expander_core.sv]
// Top level of the dashed line vertex expander
`timescale 1ns / 1ps
`include "dashed_line_vertex_expander_core_defines.svh"
// Expands one segment into move/draw polyline vertices (one vertex per output item, in
// index order, final item flagged by last_vertex). A front end takes a segment and works
// out the length (squaring through one 33x17 multiplier, then 33 square root iterations)
// and, for dashed and dash-dot segments of nonzero length, four step divisions, one
// quotient bit a cycle. A two-entry queue feeds a back end that walks the pattern once,
// phase by phase, to find the final index and then emits one vertex per cycle while
// vtx_stall does not hold it, overlapping the setup of the next segment.
module dashed_line_vertex_expander_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  output logic               seg_stall,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic               start_endside,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic               end_endside,
  input  logic [1:0]         line_style,
  input  logic [30:0]        dash_length,
  input  logic [5:0]         buffer_fill,
  output logic               vtx_valid,
  input  logic               vtx_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               pen_down,
  output logic               endside_mark,
  output logic [5:0]         vertex_index,
  output logic               last_vertex
);
  dlve_pkg::qctl_t qctl;
  dlve_pkg::seg_t  wr_rec, rd_rec;
  logic            q_full, rec_valid, rec_pop;
  logic [31:0]     ox, oy;

  dlve_setup u_setup (
    .clk, .rst, .seg_valid, .seg_stall,
    .start_x, .start_y, .start_endside, .end_x, .end_y, .end_endside,
    .line_style, .dash_length, .buffer_fill,
    .qctl_push(qctl), .q_full, .rec(wr_rec)
  );

  dlve_queue u_queue (
    .clk, .rst, .qctl_push(qctl), .wr_rec, .full(q_full),
    .pop(rec_pop), .rd_valid(rec_valid), .rd_rec
  );

  dlve_emit u_emit (
    .clk, .rst, .rec_valid, .rec_in(rd_rec), .rec_pop,
    .vtx_valid, .vtx_stall, .out_x(ox), .out_y(oy), .pen_down, .endside_mark,
    .vertex_index, .last_vertex
  );

  assign out_x = ox;
  assign out_y = oy;

  `DLVE_ASSERT_SAME(a_no_overflow, qctl.push, !q_full)
  `DLVE_ASSERT_SAME(a_pop_nonempty, rec_pop, rec_valid)
  `DLVE_ASSERT_SAME(a_index_nonzero, vtx_valid, vertex_index != 6'd0)
endmodule

[sim/dashed_line_vertex_expander_core_tb.sv]
// Self-checking testbench for the dashed line vertex expander core
`timescale 1ns / 1ps
module dashed_line_vertex_expander_core_tb;
  localparam logic [1:0] STYLE_SOLID = 2'd0;
  localparam logic [1:0] STYLE_SPARE = 2'd3;
  localparam int NUM_RANDOM = 330;

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey;
    logic               se, ee;
    logic [1:0]         style;
    logic [30:0]        dash;
    logic [5:0]         fill;
  } segment_t;

  typedef struct {
    logic [31:0] x, y;
    logic        pen, mark;
    logic [5:0]  idx;
    logic        last;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t pending_q[$];
    int      errors;

    function longint unsigned isqrt(logic [127:0] v);
      logic [127:0] r, t;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= v) r = t;
      end
      return r[63:0];
    endfunction

    function longint unsigned seg_length(segment_t s);
      longint dx, dy;
      logic [127:0] ax, ay;
      dx = longint'(s.ex) - longint'(s.sx);
      dy = longint'(s.ey) - longint'(s.sy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      return isqrt(ax * ax + ay * ay);
    endfunction

    function longint axis_step(longint unsigned c, longint d, longint unsigned len);
      logic [127:0] p, q, ad;
      ad = (d < 0) ? -d : d;
      p = c * ad;
      q = p / len;
      return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function void note_segment(segment_t s);
      longint         bx[64], by[64];
      logic           bp[64];
      longint         dx, dy, sx1, sy1, sx2, sy2, px, py, ix, iy;
      longint unsigned len, c1, c2, c, dlen;
      int             f, k, mid, ph, plen;
      vertex_t        v;
      dx = longint'(s.ex) - longint'(s.sx);
      dy = longint'(s.ey) - longint'(s.sy);
      len = seg_length(s);
      f = s.fill + 1;
      if (f > dlve_pkg::LIM - 1) f = dlve_pkg::LIM - 1;
      k = f;
      bx[k] = s.sx; by[k] = s.sy; bp[k] = 0;
      if ((s.style == dlve_pkg::STYLE_DASHED || s.style == dlve_pkg::STYLE_DASHDOT) &&
          len > 0) begin
        c1 = (s.dash != 0) ? s.dash : len;
        c2 = c1 >> 2;
        sx1 = axis_step(c1, dx, len); sy1 = axis_step(c1, dy, len);
        sx2 = axis_step(c2, dx, len); sy2 = axis_step(c2, dy, len);
        px = s.sx; py = s.sy; dlen = 0; ph = 0;
        plen = (s.style == dlve_pkg::STYLE_DASHDOT) ? 4 : 2;
        forever begin
          c  = (ph == 0) ? c1 : c2;
          ix = (ph == 0) ? sx1 : sx2;
          iy = (ph == 0) ? sy1 : sy2;
          dlen += c;
          if ((ph & 1) == 0) begin
            k++;
            if (k > dlve_pkg::LIM) begin k = dlve_pkg::LIM; break; end
            if (dlen >= len) break;
            px += ix; py += iy;
            bx[k] = px; by[k] = py; bp[k] = 1;
          end else begin
            if (dlen >= len) break;
            px += ix; py += iy;
            k++;
            if (k > dlve_pkg::LIM) begin k = dlve_pkg::LIM; break; end
            bx[k] = px; by[k] = py; bp[k] = 0;
          end
          ph = (ph + 1) % plen;
        end
      end else begin
        k = f + 1;
      end
      bx[k] = s.ex; by[k] = s.ey; bp[k] = 1;
      mid = (k + f - 1) / 2;
      for (int i = f; i <= k; i++) begin
        v.x = bx[i][31:0];
        v.y = by[i][31:0];
        v.pen = bp[i];
        v.mark = (i <= mid) ? s.se : s.ee;
        v.idx = i[5:0];
        v.last = (i == k);
        pending_q.push_back(v);
      end
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected vertex at index %0d", a.idx);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      compare("out_x", e.x, a.x);
      compare("out_y", e.y, a.y);
      compare("pen_down", 32'(e.pen), 32'(a.pen));
      compare("endside_mark", 32'(e.mark), 32'(a.mark));
      compare("vertex_index", 32'(e.idx), 32'(a.idx));
      compare("last_vertex", 32'(e.last), 32'(a.last));
    endfunction
  endclass

  logic               clk, rst;
  logic               seg_valid, seg_stall;
  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic               start_endside, end_endside;
  logic [1:0]         line_style;
  logic [30:0]        dash_length;
  logic [5:0]         buffer_fill;
  logic               vtx_valid, vtx_stall;
  logic signed [31:0] out_x, out_y;
  logic               pen_down, endside_mark, last_vertex;
  logic [5:0]         vertex_index;

  vertex_scoreboard sb;
  segment_t         directed_q[$];
  int               burst_left;

  dashed_line_vertex_expander_core u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic segment_t make_segment(logic signed [31:0] sx, logic signed [31:0] sy,
                                            logic signed [31:0] ex, logic signed [31:0] ey,
                                            logic [1:0] style, logic [30:0] dash,
                                            logic [5:0] fill);
    segment_t s;
    s.sx = sx; s.sy = sy; s.ex = ex; s.ey = ey;
    s.se = 1'($urandom_range(0, 1)); s.ee = 1'($urandom_range(0, 1));
    s.style = style; s.dash = dash; s.fill = fill;
    return s;
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    longint unsigned len;
    s.se = 1'($urandom_range(0, 1));
    s.ee = 1'($urandom_range(0, 1));
    s.style = ($urandom_range(0, 19) == 0) ? STYLE_SPARE : 2'($urandom_range(0, 2));
    s.fill = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 30));
    if ($urandom_range(0, 3) == 0) begin
      s.sx = $urandom; s.sy = $urandom; s.ex = $urandom; s.ey = $urandom;
    end else begin
      s.sx = $urandom; s.sy = $urandom;
      s.ex = s.sx + 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      s.ey = s.sy + 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
    end
    len = sb.seg_length(s);
    case ($urandom_range(0, 5))
      0:       s.dash = '0;
      1:       s.dash = 31'($urandom);
      default: s.dash = 31'(len / $urandom_range(1, 30) + $urandom_range(0, 3));
    endcase
    return s;
  endfunction

  task automatic send_segment(segment_t s);
    if (burst_left == 0) begin
      seg_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    seg_valid     <= 1'b1;
    start_x       <= s.sx;
    start_y       <= s.sy;
    start_endside <= s.se;
    end_x         <= s.ex;
    end_y         <= s.ey;
    end_endside   <= s.ee;
    line_style    <= s.style;
    dash_length   <= s.dash;
    buffer_fill   <= s.fill;
    do @(posedge clk); while (seg_stall);
    sb.note_segment(s);
  endtask

  initial begin
    vertex_t v;
    int      seen, hold_left, mode;
    bit      held;
    seen = 0; hold_left = 0; held = 0; mode = 0;
    vtx_stall <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && vtx_valid && !vtx_stall) begin
        v.x = out_x; v.y = out_y; v.pen = pen_down; v.mark = endside_mark;
        v.idx = vertex_index; v.last = last_vertex;
        sb.check_vertex(v);
        seen++;
      end
      if (!held && seen >= 150) begin
        held = 1;
        hold_left = 800;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        vtx_stall <= 1'b1;
      end else if (mode == 0) begin
        vtx_stall <= 1'b0;
      end else if (mode == 1) begin
        vtx_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        vtx_stall <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    int wait_cycles;
    sb = new();
    burst_left = 0;
    rst <= 1'b1;
    seg_valid <= 1'b0;
    start_x <= '0; start_y <= '0; end_x <= '0; end_y <= '0;
    start_endside <= 1'b0; end_endside <= 1'b0;
    line_style <= STYLE_SOLID; dash_length <= '0; buffer_fill <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_q.push_back(make_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                                      32'sh7fff_ffff, dlve_pkg::STYLE_DASHED,
                                      31'h7fff_ffff, 6'd0));
    directed_q.push_back(make_segment(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                                      32'sh7fff_ffff, dlve_pkg::STYLE_DASHDOT,
                                      31'h0100_0000, 6'd63));
    directed_q.push_back(make_segment(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000,
                                      32'sh0002_0000, dlve_pkg::STYLE_DASHED,
                                      31'h0001_0000, 6'd5));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh000a_0000,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHED, 31'd0, 6'd10));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh000a_0000,
                                      32'sh0005_0000, STYLE_SOLID, 31'h0001_0000, 6'd62));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, -32'sh000a_0000,
                                      32'sh0005_0000, STYLE_SPARE, 31'h0001_0000, 6'd61));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh000a_0000,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHED,
                                      31'h0001_0000, 6'd0));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000,
                                      -32'sh0014_0000, dlve_pkg::STYLE_DASHDOT,
                                      31'h0001_0000, 6'd3));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh000a_0000,
                                      32'sh000a_0000, dlve_pkg::STYLE_DASHED, 31'd1, 6'd0));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0064,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHDOT, 31'd3, 6'd0));
    // gap lands exactly on the end point
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh0005_0000,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHED,
                                      31'h0004_0000, 6'd7));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh0006_0000,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHDOT,
                                      31'h0004_0000, 6'd20));
    directed_q.push_back(make_segment(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0001,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHED,
                                      31'h7fff_ffff, 6'd30));
    directed_q.push_back(make_segment(-32'sh0000_0003, 32'sh0000_0004, 32'sh0000_0000,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHDOT, 31'd0, 6'd50));
    directed_q.push_back(make_segment(32'sh8000_0000, 32'sh0000_0000, 32'sh7fff_ffff,
                                      32'sh0000_0000, dlve_pkg::STYLE_DASHDOT,
                                      31'h0400_0000, 6'd1));
    foreach (directed_q[i]) send_segment(directed_q[i]);
    for (int n = 0; n < NUM_RANDOM; n++) send_segment(random_segment());
    seg_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending_q.size() != 0) $error("%0d vertices never arrived", sb.pending_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/dlve_pkg.sv
rtl/dlve_setup.sv
rtl/dlve_queue.sv
rtl/dlve_emit.sv
rtl/dashed_line_vertex_expander_core.sv
sim/dashed_line_vertex_expander_core_tb.sv
